// ----- design/rau_pkg.sv -----
// Package for the rational arithmetic unit: operation codes, states, shared widths and divider request/response types.
package rau_pkg;

  localparam int OPERAND_WIDTH_DEF = 32;
  localparam int MAG_W = 64;

  localparam logic [2:0] OP_NORM = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;
  localparam logic [2:0] OP_EQ   = 3'd5;
  localparam logic [2:0] OP_LT   = 3'd6;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RA_GCD,
    ST_RA_DIV_N,
    ST_RA_DIV_D,
    ST_RB_GCD,
    ST_RB_DIV_N,
    ST_RB_DIV_D,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_COMBINE,
    ST_RR_GCD,
    ST_RR_DIV_N,
    ST_RR_DIV_D,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                  start;
    logic [MAG_W-1:0]      dividend;
    logic [MAG_W-1:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [MAG_W-1:0]      quotient;
    logic [MAG_W-1:0]      remainder;
  } div_rsp_t;

endpackage

// ----- design/rau_divider.sv -----
// Restoring radix-2 divider for 64-bit unsigned magnitudes, one quotient bit per cycle.
module rau_divider (
  input  logic              clk,
  input  logic              rst,
  input  rau_pkg::div_req_t req,
  output rau_pkg::div_rsp_t rsp
);

  localparam int W = rau_pkg::MAG_W;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  quo;
  logic [W-1:0]  rem;
  logic [W-1:0]  dsr;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic [W:0]    trial;
  logic [W:0]    shifted;

  always_comb begin
    shifted = {rem, quo[W-1]};
    trial   = shifted - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
        quo  <= req.dividend;
        rem  <= '0;
        dsr  <= req.divisor;
      end else if (busy) begin
        if (trial[W]) begin
          rem <= shifted[W-1:0];
          quo <= {quo[W-2:0], 1'b0};
        end else begin
          rem <= trial[W-1:0];
          quo <= {quo[W-2:0], 1'b1};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy      = busy;
  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

// ----- design/rational_arith_unit.sv -----
// Top level of the rational arithmetic unit: sequencer around one shared divider.
//
// Usage: the upstream side presents a request (req_type and the two fractions
// A = a_num/a_den, B = b_num/b_den) with in_valid; the request is taken at a
// clock edge where in_valid is high and in_stall is low. The block drops
// into a busy sequence and holds in_stall high until the result has been
// handed over. Each operand is reduced to lowest terms, the operation is
// carried out, and the result is reduced again, with the sign on the
// numerator and zero written as 0/1. Compares give cmp_true and 0/0; a zero
// denominator, or a zero divisor in a division, gives bad_den and 0/0.
// Every GCD runs Euclid's algorithm with one modulo at a time through the
// single restoring divider, and each reduction also spends two divisions
// to scale numerator and denominator. A request with an error goes straight
// to the done state and uses no division.
// The result waits in an output register with out_valid high; while
// out_stall is high it holds, and no new request is taken until it leaves.
// Reset (rst, synchronous) returns the sequencer to idle and drops out_valid.
module rational_arith_unit #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               req_type,
  input  logic signed [31:0]       a_num,
  input  logic signed [31:0]       a_den,
  input  logic signed [31:0]       b_num,
  input  logic signed [31:0]       b_den,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [63:0]       res_num,
  output logic [61:0]              res_den,
  output logic                     cmp_true,
  output logic                     bad_den
);

  localparam int W = rau_pkg::MAG_W;
  localparam int OW = OPERAND_WIDTH;

  // Operand capture: sign-extend from OW bits and clamp the most negative code.
  function automatic logic signed [W-1:0] take_op(input logic [31:0] raw);
    logic [OW-1:0]        v;
    logic signed [W-1:0]  s;
    v = raw[OW-1:0];
    s = W'(signed'(v));
    if (v == {1'b1, {(OW-1){1'b0}}}) s = s + 1;
    return s;
  endfunction

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
    return v[W-1] ? W'(-v) : W'(v);
  endfunction

  // Reduced operands fit in 32 signed bits, so a 32x32 product is enough.
  function automatic logic signed [W-1:0] smul(input logic signed [31:0] x,
                                               input logic signed [31:0] y);
    return x * y;
  endfunction

  rau_pkg::state_t state, state_next;
  rau_pkg::div_req_t dreq;
  rau_pkg::div_rsp_t drsp;

  logic [2:0]            op;
  logic signed [W-1:0]   an, ad, bn, bd;      // operands, later reduced forms
  logic [W-1:0]          gx, gy;              // Euclid working pair
  logic [W-1:0]          rn_mag, rd_mag;      // value under reduction
  logic                  rneg;
  logic signed [W-1:0]   t1, t2, t3;          // cross products
  logic                  issued;
  logic                  out_v;
  logic signed [W-1:0]   o_num;
  logic [61:0]           o_den;
  logic                  o_cmp, o_bad;

  assign in_stall  = (state != rau_pkg::ST_IDLE) || out_v;
  assign out_valid = out_v;
  assign res_num   = o_num;
  assign res_den   = o_den;
  assign cmp_true  = o_cmp;
  assign bad_den   = o_bad;

  rau_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic gcd_end;
  logic [W-1:0] gval;
  assign gcd_end = (gx == '0) || (gy == '0);
  assign gval    = gx + gy;

  always_comb begin
    state_next = state;
    unique case (state)
      rau_pkg::ST_IDLE:     if (in_valid && !in_stall) state_next = rau_pkg::ST_RA_GCD;
      rau_pkg::ST_DONE:     state_next = rau_pkg::ST_IDLE;
      default:              state_next = state;
    endcase
  end

  // One shared sequencer; the divider start is pulsed once per division step.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= rau_pkg::ST_IDLE;
      out_v  <= 1'b0;
      issued <= 1'b0;
      dreq   <= '0;
    end else begin
      dreq.start <= 1'b0;
      if (out_v && !out_stall) out_v <= 1'b0;
      unique case (state)
        rau_pkg::ST_IDLE: begin
          if (in_valid && !in_stall) begin
            op <= req_type;
            an <= take_op(a_num);
            ad <= take_op(a_den);
            bn <= take_op(b_num);
            bd <= take_op(b_den);
            o_num <= '0; o_den <= '0; o_cmp <= 1'b0; o_bad <= 1'b0;
            issued <= 1'b0;
            if (req_type > rau_pkg::OP_LT) state <= rau_pkg::ST_DONE;
            else if (take_op(a_den) == '0
                     || (req_type != rau_pkg::OP_NORM && take_op(b_den) == '0)
                     || (req_type == rau_pkg::OP_DIV && take_op(b_num) == '0)) begin
              o_bad <= 1'b1;
              state <= rau_pkg::ST_DONE;
            end else begin
              rn_mag <= mag(take_op(a_num));
              rd_mag <= mag(take_op(a_den));
              gx     <= mag(take_op(a_num));
              gy     <= mag(take_op(a_den));
              rneg   <= a_num[OW-1] ^ a_den[OW-1];
              state  <= rau_pkg::ST_RA_GCD;
            end
          end
        end
        rau_pkg::ST_RA_GCD, rau_pkg::ST_RB_GCD, rau_pkg::ST_RR_GCD: begin
          if (!issued) begin
            if (gcd_end) begin
              // Scale numerator by the GCD next.
              dreq.start    <= 1'b1;
              dreq.dividend <= rn_mag;
              dreq.divisor  <= gval;
              issued        <= 1'b1;
              state <= (state == rau_pkg::ST_RA_GCD) ? rau_pkg::ST_RA_DIV_N :
                       (state == rau_pkg::ST_RB_GCD) ? rau_pkg::ST_RB_DIV_N :
                                                       rau_pkg::ST_RR_DIV_N;
            end else begin
              dreq.start    <= 1'b1;
              dreq.dividend <= (gx > gy) ? gx : gy;
              dreq.divisor  <= (gx > gy) ? gy : gx;
              issued        <= 1'b1;
            end
          end else if (drsp.done) begin
            issued <= 1'b0;
            if (gx > gy) gx <= drsp.remainder;
            else         gy <= drsp.remainder;
          end
        end
        rau_pkg::ST_RA_DIV_N, rau_pkg::ST_RB_DIV_N, rau_pkg::ST_RR_DIV_N: begin
          if (drsp.done) begin
            rn_mag        <= drsp.quotient;
            dreq.start    <= 1'b1;
            dreq.dividend <= rd_mag;
            dreq.divisor  <= gval;
            state <= (state == rau_pkg::ST_RA_DIV_N) ? rau_pkg::ST_RA_DIV_D :
                     (state == rau_pkg::ST_RB_DIV_N) ? rau_pkg::ST_RB_DIV_D :
                                                       rau_pkg::ST_RR_DIV_D;
          end
        end
        rau_pkg::ST_RA_DIV_D, rau_pkg::ST_RB_DIV_D, rau_pkg::ST_RR_DIV_D: begin
          if (drsp.done) begin
            issued <= 1'b0;
            if (state == rau_pkg::ST_RA_DIV_D) begin
              an <= (rn_mag == '0) ? '0 : (rneg ? W'(-rn_mag) : W'(rn_mag));
              ad <= (rn_mag == '0) ? W'(1) : W'(drsp.quotient);
              if (op == rau_pkg::OP_NORM) begin
                state <= rau_pkg::ST_COMBINE;
              end else begin
                rn_mag <= mag(bn); rd_mag <= mag(bd);
                gx <= mag(bn); gy <= mag(bd);
                rneg <= bn[W-1] ^ bd[W-1];
                state <= rau_pkg::ST_RB_GCD;
              end
            end else if (state == rau_pkg::ST_RB_DIV_D) begin
              bn <= (rn_mag == '0) ? '0 : (rneg ? W'(-rn_mag) : W'(rn_mag));
              bd <= (rn_mag == '0) ? W'(1) : W'(drsp.quotient);
              state <= rau_pkg::ST_M1;
            end else begin
              o_num <= (rn_mag == '0) ? '0 : (rneg ? W'(-rn_mag) : W'(rn_mag));
              o_den <= (rn_mag == '0) ? 62'd1 : drsp.quotient[61:0];
              state <= rau_pkg::ST_DONE;
            end
          end
        end
        // Cross products, one 32x32-class multiply per cycle.
        rau_pkg::ST_M1: begin
          t1 <= (op == rau_pkg::OP_MUL) ? smul(an[31:0], bn[31:0]) : smul(an[31:0], bd[31:0]);
          state <= rau_pkg::ST_M2;
        end
        rau_pkg::ST_M2: begin
          t2 <= smul(ad[31:0], bn[31:0]);
          state <= rau_pkg::ST_M3;
        end
        rau_pkg::ST_M3: begin
          t3 <= smul(ad[31:0], bd[31:0]);
          state <= rau_pkg::ST_COMBINE;
        end
        rau_pkg::ST_COMBINE: begin
          case (op)
            rau_pkg::OP_NORM: begin
              o_num <= an; o_den <= ad[61:0]; state <= rau_pkg::ST_DONE;
            end
            rau_pkg::OP_EQ: begin
              o_cmp <= (an == bn) && (ad == bd); state <= rau_pkg::ST_DONE;
            end
            rau_pkg::OP_LT: begin
              o_cmp <= (t1 < t2); state <= rau_pkg::ST_DONE;
            end
            rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
              logic signed [W-1:0] s;
              s = (op == rau_pkg::OP_ADD) ? t1 + t2 : t1 - t2;
              rn_mag <= mag(s); rd_mag <= mag(t3);
              gx <= mag(s); gy <= mag(t3);
              rneg <= s[W-1] ^ t3[W-1];
              state <= rau_pkg::ST_RR_GCD;
            end
            rau_pkg::OP_MUL: begin
              rn_mag <= mag(t1); rd_mag <= mag(t3);
              gx <= mag(t1); gy <= mag(t3);
              rneg <= t1[W-1] ^ t3[W-1];
              state <= rau_pkg::ST_RR_GCD;
            end
            default: begin
              rn_mag <= mag(t1); rd_mag <= mag(t2);
              gx <= mag(t1); gy <= mag(t2);
              rneg <= t1[W-1] ^ t2[W-1];
              state <= rau_pkg::ST_RR_GCD;
            end
          endcase
        end
        rau_pkg::ST_DONE: begin
          out_v <= 1'b1;
          state <= state_next;
        end
        default: state <= rau_pkg::ST_IDLE;
      endcase
    end
  end

  // The divider is only started while it is idle.
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    dreq.start |-> !drsp.busy) else $error("divider restarted while busy");
  // A result is only raised from the done state.
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_v) |-> $past(state) == rau_pkg::ST_DONE) else $error("stray result");
  // No request is taken while a result is still pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_v |-> in_stall) else $error("request accepted during pending result");
  // An error result is always 0/0 with no compare flag.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_v && o_bad) |-> (o_num == '0 && o_den == '0 && !o_cmp))
    else $error("error result not 0/0");

endmodule

// ----- bench/rational_arith_unit_test.sv -----
// Self-checking testbench for the rational arithmetic unit, with a scoreboard class.
module rational_arith_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  // One expected or observed result of a request.
  typedef struct {
    longint          num;
    logic [61:0]     den;
    logic            cmp;
    logic            bad;
  } frac_result_t;

  // The scoreboard predicts the answer of each accepted request and
  // matches the answers that come out of the block in order.
  class frac_scoreboard;
    frac_result_t pending_q[$];
    int           errors;

    function new();
      errors = 0;
    endfunction

    // The operand field as the block sees it: two's complement, with the
    // most negative value clamped one step toward zero.
    function longint operand_value(logic [31:0] raw);
      if (raw == 32'h8000_0000) return -longint'(32'h7fff_ffff);
      return longint'($signed(raw));
    endfunction

    function longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
      while (x > 0 && y > 0) begin
        if (x > y) x = x % y;
        else y = y % x;
      end
      return x + y;
    endfunction

    // Lowest terms with the sign on the numerator and zero as 0/1.
    function void lowest_terms(longint n, longint d, output longint rn,
                               output longint unsigned rd);
      bit neg;
      longint unsigned mn, md, g;
      neg = (n < 0) != (d < 0);
      mn = (n < 0) ? longint'(-n) : n;
      md = (d < 0) ? longint'(-d) : d;
      g = euclid_gcd(mn, md);
      if (g > 1) begin
        mn = mn / g;
        md = md / g;
      end
      if (mn == 0) begin
        rd = 1;
        rn = 0;
      end else begin
        rd = md;
        rn = neg ? -longint'(mn) : longint'(mn);
      end
    endfunction

    function void note_request(logic [2:0] op, logic [31:0] an_raw, logic [31:0] ad_raw,
                               logic [31:0] bn_raw, logic [31:0] bd_raw);
      frac_result_t r;
      longint an, ad, bn, bd, an_r, bn_r, sad, sbd;
      longint unsigned ad_r, bd_r, rd;
      an = operand_value(an_raw);
      ad = operand_value(ad_raw);
      bn = operand_value(bn_raw);
      bd = operand_value(bd_raw);
      r.num = 0;
      r.den = '0;
      r.cmp = 1'b0;
      r.bad = 1'b0;
      rd = 0;
      if (op <= rau_pkg::OP_LT) begin
        if (ad == 0 || (op != rau_pkg::OP_NORM && bd == 0)
            || (op == rau_pkg::OP_DIV && bn == 0)) begin
          r.bad = 1'b1;
        end else begin
          bd_r = 1;
          bn_r = 0;
          lowest_terms(an, ad, an_r, ad_r);
          if (op != rau_pkg::OP_NORM) lowest_terms(bn, bd, bn_r, bd_r);
          sad = ad_r;
          sbd = bd_r;
          case (op)
            rau_pkg::OP_NORM: begin
              r.num = an_r;
              rd = ad_r;
            end
            rau_pkg::OP_ADD: lowest_terms(an_r * sbd + bn_r * sad, sad * sbd, r.num, rd);
            rau_pkg::OP_SUB: lowest_terms(an_r * sbd - bn_r * sad, sad * sbd, r.num, rd);
            rau_pkg::OP_MUL: lowest_terms(an_r * bn_r, sad * sbd, r.num, rd);
            rau_pkg::OP_DIV: lowest_terms(an_r * sbd, sad * bn_r, r.num, rd);
            rau_pkg::OP_EQ: r.cmp = (an_r == bn_r && ad_r == bd_r);
            default: r.cmp = (an_r * sbd < bn_r * sad);
          endcase
          r.den = rd[61:0];
        end
      end
      pending_q.push_back(r);
    endfunction

    function void check_result(frac_result_t got);
      frac_result_t exp;
      if (pending_q.size() == 0) begin
        $display("%0t: result with no request waiting: %0d/%0d", $time, got.num, got.den);
        errors++;
        return;
      end
      exp = pending_q.pop_front();
      if (got.num !== exp.num) begin
        $display("%0t: res_num expected %0d actual %0d", $time, exp.num, got.num);
        errors++;
      end
      if (got.den !== exp.den) begin
        $display("%0t: res_den expected %0d actual %0d", $time, exp.den, got.den);
        errors++;
      end
      if (got.cmp !== exp.cmp) begin
        $display("%0t: cmp_true expected %0b actual %0b", $time, exp.cmp, got.cmp);
        errors++;
      end
      if (got.bad !== exp.bad) begin
        $display("%0t: bad_den expected %0b actual %0b", $time, exp.bad, got.bad);
        errors++;
      end
    endfunction

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  localparam int STALL_LIMIT = 60000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         req_type = '0;
  logic signed [31:0] a_num = '0;
  logic signed [31:0] a_den = 32'sd1;
  logic signed [31:0] b_num = '0;
  logic signed [31:0] b_den = 32'sd1;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [63:0] res_num;
  logic [61:0]        res_den;
  logic               cmp_true;
  logic               bad_den;

  frac_scoreboard sb = new();

  // Idle percentages for each side, changed between phases.
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  // Set by the main sequence; the receiver turns it into a long hold-off.
  bit  hold_off_req = 0;
  int  idle_cycles = 0;

  rational_arith_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
    .out_valid(out_valid), .out_stall(out_stall),
    .res_num(res_num), .res_den(res_den), .cmp_true(cmp_true), .bad_den(bad_den)
  );

  always #4 clk = ~clk;

  // Receiver: samples outputs at the rising edge, then picks the next stall.
  initial begin : receiver
    frac_result_t got;
    int hold_cnt;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got.num = res_num;
        got.den = res_den;
        got.cmp = cmp_true;
        got.bad = bad_den;
        sb.check_result(got);
      end
      if (hold_off_req) begin
        hold_off_req = 0;
        hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a request or result.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("rational_arith_unit_test: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one request and waits at the clock edges until it is taken.
  // Valid stays high between back-to-back requests.
  task automatic send_request(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
                              logic [31:0] bn, logic [31:0] bd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= op;
    a_num <= an;
    a_den <= ad;
    b_num <= bn;
    b_den <= bd;
    do @(posedge clk); while (in_stall);
    sb.note_request(op, an, ad, bn, bd);
  endtask

  // Operand values: mostly small so GCD chains stay short, some full width,
  // some corner values, and occasional zero.
  function automatic logic [31:0] pick_operand();
    int sel;
    sel = $urandom_range(99);
    if (sel < 6) return 32'h0;
    if (sel < 12) begin
      case ($urandom_range(5))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h8000_0001;
        3: return 32'h0000_0001;
        4: return 32'hffff_ffff;
        default: return 32'h0001_0000;
      endcase
    end
    if (sel < 30) return $urandom();
    if (sel < 55) return 32'($signed($urandom_range(200000)) - 100000);
    return 32'($signed($urandom_range(80)) - 40);
  endfunction

  task automatic random_phase(int count);
    logic [2:0] op;
    repeat (count) begin
      op = ($urandom_range(49) == 0) ? 3'd7 : 3'($urandom_range(6));
      send_request(op, pick_operand(), pick_operand(), pick_operand(), pick_operand());
    end
  endtask

  initial begin : main
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests: each operation, zero denominators, division by
    // zero, the unused selector, zero results and the field extremes.
    send_request(rau_pkg::OP_NORM, 32'sd6, -32'sd4, 32'sd0, 32'sd0);
    send_request(rau_pkg::OP_NORM, 32'sd0, -32'sd7, 32'sd5, 32'sd3);
    send_request(rau_pkg::OP_NORM, 32'sd3, 32'sd0, 32'sd1, 32'sd1);
    send_request(rau_pkg::OP_ADD, 32'sd1, 32'sd2, 32'sd1, 32'sd3);
    send_request(rau_pkg::OP_ADD, 32'sd1, 32'sd2, -32'sd1, 32'sd2);
    send_request(rau_pkg::OP_SUB, 32'sd3, 32'sd4, 32'sd5, -32'sd6);
    send_request(rau_pkg::OP_MUL, -32'sd2, 32'sd3, 32'sd9, 32'sd4);
    send_request(rau_pkg::OP_DIV, 32'sd2, 32'sd3, -32'sd4, 32'sd9);
    send_request(rau_pkg::OP_DIV, 32'sd2, 32'sd3, 32'sd0, 32'sd9);
    send_request(rau_pkg::OP_EQ, 32'sd2, 32'sd4, -32'sd3, -32'sd6);
    send_request(rau_pkg::OP_EQ, 32'sd2, 32'sd4, 32'sd1, 32'sd3);
    send_request(rau_pkg::OP_LT, 32'sd1, 32'sd3, 32'sd1, 32'sd2);
    send_request(rau_pkg::OP_LT, 32'sd1, 32'sd2, 32'sd1, 32'sd2);
    send_request(rau_pkg::OP_ADD, 32'sd1, 32'sd1, 32'sd1, 32'sd0);
    send_request(3'd7, 32'sd1, 32'sd1, 32'sd1, 32'sd1);
    send_request(rau_pkg::OP_ADD, 32'h7fff_ffff, 32'h7fff_fffe, 32'h7fff_fffe,
                 32'h7fff_ffff);
    send_request(rau_pkg::OP_MUL, 32'h8000_0000, 32'sd1, 32'h8000_0000, 32'sd1);
    send_request(rau_pkg::OP_DIV, 32'sd1, 32'h8000_0000, 32'sd1, 32'h7fff_ffff);
    send_request(rau_pkg::OP_SUB, 32'h8000_0000, 32'h7fff_fffd, 32'h7fff_ffff,
                 32'h8000_0001);
    send_request(rau_pkg::OP_LT, 32'h8000_0000, 32'sd1, 32'h7fff_ffff, 32'sd1);
    send_request(rau_pkg::OP_EQ, 32'h8000_0000, 32'h8000_0000, 32'sd1, 32'sd1);
    send_request(rau_pkg::OP_NORM, 32'sd1836311903, 32'sd1134903170, 32'sd0, 32'sd1);

    // Sender idles now and then while the receiver stalls more often than not.
    send_idle_pct = 26;
    recv_idle_pct = 55;
    random_phase(200);
    // Long hold-off at the output while requests keep coming.
    hold_off_req = 1;
    random_phase(200);

    send_idle_pct = 55;
    recv_idle_pct = 26;
    random_phase(200);
    // Let the block drain completely before offering more.
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    random_phase(200);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(400);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("rational_arith_unit_test: PASS");
    end else begin
      $display("rational_arith_unit_test: FAIL");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
design/rau_pkg.sv
design/rau_divider.sv
design/rational_arith_unit.sv
bench/rational_arith_unit_test.sv
